// File: hdl/ant_tour_next_city_selector_macros.svh
// assertion macros for the ant tour next city selector checker
// no dependencies; the user module must have a clock named clk
`ifndef ANT_TOUR_NEXT_CITY_SELECTOR_MACROS_SVH
`define ANT_TOUR_NEXT_CITY_SELECTOR_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define ANTS_ASSERT_SAME(lbl, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("ants assertion failed");

// consequent holds in the cycle after the antecedent
`define ANTS_ASSERT_NEXT(lbl, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("ants assertion failed");

`endif

// File: hdl/ants_pkg.sv
// shared types and constants for the ant tour next city selector
// no dependencies
`timescale 1ns / 1ps

package ants_pkg;

  localparam int CITY_W     = 6;
  localparam int WORD_W     = 32;
  localparam int CFG_W      = 7;
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int FIFO_DEPTH = 2;
  localparam int STEP_W     = 5;

  localparam logic [CFG_W-1:0] CITIES_RESET = 7'd64;
  localparam logic [0:0]       REG_CITIES   = 1'b0;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2
  } opcode_t;

  typedef struct packed {
    opcode_t             op;
    logic [CITY_W-1:0]   row;
    logic [CITY_W-1:0]   col;
    logic [WORD_W-1:0]   word;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_MUL  = 4'b0100,
    S_PICK = 4'b1000
  } eng_state_t;

endpackage

// File: hdl/ants_cmd_front.sv
// command front end: classifies accepted beats and queues them
// depends on ants_pkg
`timescale 1ns / 1ps

module ants_cmd_front import ants_pkg::*; #(
  parameter int MAX_CITIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        opcode,
  input  logic [CITY_W-1:0] from_city,
  input  logic [CITY_W-1:0] to_city,
  input  logic [WORD_W-1:0] pheromone_value,
  input  logic [WORD_W-1:0] random_word,
  input  logic              pop,
  output cmd_t              head,
  output logic              head_vld
);

  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  cmd_t       q_r [FIFO_DEPTH];
  cmd_t       item;
  logic       keep;
  logic       push;
  logic       take;

  assign busy     = (cnt_r == 2'(FIFO_DEPTH));
  assign head_vld = (cnt_r != 2'd0);
  assign head     = q_r[rd_ptr_r];

  always_comb begin
    keep      = 1'b0;
    item.op   = opcode_t'(opcode);
    item.row  = from_city;
    item.col  = to_city;
    item.word = '0;
    case (opcode)
      OP_WRITE: begin
        keep      = (int'(from_city) < MAX_CITIES) && (int'(to_city) < MAX_CITIES);
        item.word = pheromone_value;
      end
      OP_START: keep = 1'b1;
      OP_STEP: begin
        keep      = 1'b1;
        item.word = random_word;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = start && !busy && keep;
  assign take = pop && head_vld;

  always_comb begin
    cnt_nxt    = cnt_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (take) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !take) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (take && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

endmodule

// File: hdl/ants_frac_mul.sv
// bit-serial fraction multiplier: floor(r * a / 2^32), one bit of r per cycle
// depends on ants_pkg
`timescale 1ns / 1ps

module ants_frac_mul import ants_pkg::*; #(
  parameter int OPW = 38
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [OPW-1:0]    a,
  input  logic [WORD_W-1:0] r,
  output logic              done,
  output logic [OPW-1:0]    prod
);

  logic [OPW-1:0]    acc_r;
  logic [OPW-1:0]    a_r;
  logic [WORD_W-1:0] r_r;
  logic [STEP_W-1:0] step_r;
  logic              run_r;
  logic              done_r;
  logic [OPW:0]      sum;

  assign sum  = {1'b0, acc_r} + (r_r[0] ? {1'b0, a_r} : '0);
  assign done = done_r;
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
      end else if (run_r && step_r == STEP_W'(WORD_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc_r  <= '0;
      a_r    <= a;
      r_r    <= r;
      step_r <= '0;
    end else if (run_r) begin
      acc_r  <= sum[OPW:1];
      r_r    <= r_r >> 1;
      step_r <= step_r + STEP_W'(1);
    end
  end

endmodule

// File: hdl/ants_tour_engine.sv
// tour engine: pheromone memory, visited set and the two-pass city pick
// depends on ants_pkg and ants_frac_mul
`timescale 1ns / 1ps

module ants_tour_engine import ants_pkg::*; #(
  parameter int MAX_CITIES     = 64,
  parameter int PHEROMONE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CFG_W-1:0]  cities,
  input  cmd_t              head,
  input  logic              head_vld,
  output logic              pop,
  output logic              out_valid,
  output logic [CITY_W-1:0] out_next_city,
  output logic              out_chose_uniformly,
  output logic              out_tour_done
);

  localparam int CW    = $clog2(MAX_CITIES);
  localparam int NW    = $clog2(MAX_CITIES + 1);
  localparam int TW    = PHEROMONE_BITS + CW;
  localparam int DEPTH = 1 << (2 * CW);

  logic [PHEROMONE_BITS-1:0] mem [DEPTH];
  logic [PHEROMONE_BITS-1:0] rd_data_r;
  logic [2*CW-1:0]           rd_addr;
  logic [2*CW-1:0]           wr_addr;
  logic                      mem_we;

  eng_state_t         state_r, state_nxt;
  logic [NW-1:0]      cnt_r, cnt_nxt;
  logic [TW-1:0]      total_r, total_nxt;
  logic [NW-1:0]      unv_r, unv_nxt;
  logic [TW-1:0]      thr_r, thr_nxt;
  logic               uni_r, uni_nxt;
  logic [WORD_W-1:0]  rnd_r, rnd_nxt;
  logic [TW-1:0]      run_r, run_nxt;
  logic [NW-1:0]      seen_r, seen_nxt;
  logic [MAX_CITIES-1:0] visited_r, visited_nxt;
  logic [CW-1:0]      cur_r, cur_nxt;
  logic [NW-1:0]      steps_r, steps_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CITY_W-1:0]  out_city_r, out_city_nxt;
  logic               out_uni_r, out_uni_nxt;
  logic               out_done_r, out_done_nxt;

  logic [NW-1:0]  n_eff;
  logic [NW:0]    n_ext;
  logic [NW:0]    step_plus;
  logic [CW-1:0]  jdx;
  logic           live;
  logic [TW-1:0]  acc_total;
  logic [NW-1:0]  acc_unv;
  logic [TW-1:0]  run_sum;
  logic           hit;
  logic           mul_go;
  logic [TW-1:0]  mul_a;
  logic           mul_done;
  logic [TW-1:0]  mul_prod;

  ants_frac_mul #(
    .OPW (TW)
  ) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (mul_go),
    .a    (mul_a),
    .r    (rnd_r),
    .done (mul_done),
    .prod (mul_prod)
  );

  assign n_eff     = (int'(cities) > MAX_CITIES) ? NW'(MAX_CITIES) : NW'(cities);
  assign n_ext     = {1'b0, n_eff};
  assign step_plus = {1'b0, steps_r} + (NW + 1)'(1);
  assign jdx       = CW'(cnt_r - NW'(1));
  assign live      = (cnt_r != '0) && !visited_r[jdx];
  assign acc_total = live ? total_r + TW'(rd_data_r) : total_r;
  assign acc_unv   = live ? unv_r + NW'(1) : unv_r;
  assign run_sum   = run_r + TW'(rd_data_r);
  assign hit       = live && (uni_r ? (TW'(seen_r) == thr_r) : (run_sum > thr_r));

  assign rd_addr = {cur_r, cnt_r[CW-1:0]};
  assign wr_addr = {CW'(head.row), CW'(head.col)};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= PHEROMONE_BITS'(head.word);
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    total_nxt     = total_r;
    unv_nxt       = unv_r;
    thr_nxt       = thr_r;
    uni_nxt       = uni_r;
    rnd_nxt       = rnd_r;
    run_nxt       = run_r;
    seen_nxt      = seen_r;
    visited_nxt   = visited_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    out_valid_nxt = 1'b0;
    out_city_nxt  = out_city_r;
    out_uni_nxt   = out_uni_r;
    out_done_nxt  = out_done_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mul_go        = 1'b0;
    mul_a         = '0;
    case (state_r)
      S_IDLE: begin
        if (head_vld) begin
          pop = 1'b1;
          case (head.op)
            OP_WRITE: mem_we = 1'b1;
            OP_START: begin
              visited_nxt = MAX_CITIES'(1);
              cur_nxt     = '0;
              steps_nxt   = '0;
            end
            OP_STEP: begin
              // tour already complete: drop the beat
              if (step_plus < n_ext) begin
                cnt_nxt   = '0;
                total_nxt = '0;
                unv_nxt   = '0;
                rnd_nxt   = head.word;
                state_nxt = S_SUM;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      S_SUM: begin
        total_nxt = acc_total;
        unv_nxt   = acc_unv;
        if (cnt_r == n_eff) begin
          if (acc_unv == '0) begin
            state_nxt = S_IDLE;
          end else begin
            uni_nxt   = (acc_total == '0);
            mul_go    = 1'b1;
            mul_a     = (acc_total == '0) ? TW'(acc_unv) : acc_total;
            state_nxt = S_MUL;
          end
        end else begin
          cnt_nxt = cnt_r + NW'(1);
        end
      end
      S_MUL: begin
        if (mul_done) begin
          thr_nxt   = mul_prod;
          cnt_nxt   = '0;
          run_nxt   = '0;
          seen_nxt  = '0;
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        if (live) begin
          run_nxt  = run_sum;
          seen_nxt = seen_r + NW'(1);
        end
        if (hit) begin
          visited_nxt[jdx] = 1'b1;
          cur_nxt          = jdx;
          steps_nxt        = steps_r + NW'(1);
          out_valid_nxt    = 1'b1;
          out_city_nxt     = CITY_W'(jdx);
          out_uni_nxt      = uni_r;
          out_done_nxt     = (step_plus + (NW + 1)'(1)) >= n_ext;
          state_nxt        = S_IDLE;
        end else if (cnt_r == n_eff) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + NW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      visited_r   <= MAX_CITIES'(1);
      cur_r       <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      visited_r   <= visited_nxt;
      cur_r       <= cur_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    total_r    <= total_nxt;
    unv_r      <= unv_nxt;
    thr_r      <= thr_nxt;
    uni_r      <= uni_nxt;
    rnd_r      <= rnd_nxt;
    run_r      <= run_nxt;
    seen_r     <= seen_nxt;
    out_city_r <= out_city_nxt;
    out_uni_r  <= out_uni_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_next_city       = out_city_r;
  assign out_chose_uniformly = out_uni_r;
  assign out_tour_done       = out_done_r;

endmodule

// File: hdl/ant_tour_next_city_selector.sv
// Ant tour next city selector, top level.
// Command channel: a beat is taken when start is high and busy is low. in_opcode
// selects a pheromone table write (in_from_city, in_to_city, in_pheromone_value),
// a tour start, or a next-city step (in_random_word). Opcode 3 and writes outside
// the table are dropped. Accepted beats go into a two-entry queue; busy is high
// while the queue is full.
// Result channel: out_valid is high for one cycle with out_next_city,
// out_chose_uniformly and out_tour_done; the receiver cannot stall it.
// Writes and starts are handled in the engine's idle state and give no result.
// A step makes one pass over the table row to total the unvisited pheromone
// (one memory read port), a bit-serial scaling of the random fraction, then a
// second row pass for the pick, which ends at the first city chosen.
// Register cities_in_use at byte address 0 on the APB port, reset 64.
// Reset clears the queue, the engine and the tour (only city zero visited);
// the pheromone table is not cleared and must be written before use.
// Depends on ants_pkg, ants_cmd_front, ants_tour_engine.
`timescale 1ns / 1ps

module ant_tour_next_city_selector import ants_pkg::*; #(
  parameter int MAX_CITIES     = 64,
  parameter int PHEROMONE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_opcode,
  input  logic [CITY_W-1:0]     in_from_city,
  input  logic [CITY_W-1:0]     in_to_city,
  input  logic [WORD_W-1:0]     in_pheromone_value,
  input  logic [WORD_W-1:0]     in_random_word,
  output logic                  out_valid,
  output logic [CITY_W-1:0]     out_next_city,
  output logic                  out_chose_uniformly,
  output logic                  out_tour_done,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CFG_W-1:0] cfg_cities_r;
  logic [0:0]       cfg_idx;
  logic             cfg_wr;
  cmd_t             head;
  logic             head_vld;
  logic             pop;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (cfg_idx == REG_CITIES) ? APB_DATA_W'(cfg_cities_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cities_r <= CITIES_RESET;
    end else if (cfg_wr && cfg_idx == REG_CITIES) begin
      cfg_cities_r <= pwdata[CFG_W-1:0];
    end
  end

  ants_cmd_front #(
    .MAX_CITIES(MAX_CITIES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .opcode         (in_opcode),
    .from_city      (in_from_city),
    .to_city        (in_to_city),
    .pheromone_value(in_pheromone_value),
    .random_word    (in_random_word),
    .pop            (pop),
    .head           (head),
    .head_vld       (head_vld)
  );

  ants_tour_engine #(
    .MAX_CITIES    (MAX_CITIES),
    .PHEROMONE_BITS(PHEROMONE_BITS)
  ) u_engine (
    .clk                (clk),
    .rst_n              (rst_n),
    .cities             (cfg_cities_r),
    .head               (head),
    .head_vld           (head_vld),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_next_city      (out_next_city),
    .out_chose_uniformly(out_chose_uniformly),
    .out_tour_done      (out_tour_done)
  );

endmodule

// File: hdl/ants_checker.sv
// port-level checker for the ant tour next city selector, bound to the top
// depends on ants_pkg and ant_tour_next_city_selector_macros.svh
`timescale 1ns / 1ps
`include "ant_tour_next_city_selector_macros.svh"

module ants_checker import ants_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              busy,
  input logic              out_valid,
  input logic [CITY_W-1:0] out_next_city
);

  `ANTS_ASSERT_NEXT(a_busy_after_reset, 1'b0, !rst_n, !busy)
  `ANTS_ASSERT_NEXT(a_no_result_after_reset, 1'b0, !rst_n, !out_valid)
  `ANTS_ASSERT_NEXT(a_result_single_cycle, !rst_n, out_valid, !out_valid)
  `ANTS_ASSERT_SAME(a_never_city_zero, !rst_n, out_valid, out_next_city != '0)

endmodule

bind ant_tour_next_city_selector ants_checker u_ants_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_next_city(out_next_city)
);

// File: tb/sv/tb.sv
// self-checking testbench for the ant tour next city selector: loads the pheromone table,
// runs a directed table and random tours over several city counts against a local predictor
// depends on ants_pkg and ant_tour_next_city_selector
`timescale 1ns / 1ps

module tb;
  import ants_pkg::*;

  localparam int          MAX_C        = 64;
  localparam int          FILL_N       = 31;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          CFG_SETTLE   = 600;
  localparam int          DRAIN_LIMIT  = 40000;
  localparam int unsigned LIMIT        = 10_000_000;
  localparam int          PRINT_CAP    = 100;
  localparam int          NUM_PHASES   = 16;
  localparam int          NUM_DIRECTED = 21;

  typedef struct packed {
    logic [CITY_W-1:0] city;
    logic              uni;
    logic              done;
  } city_pick_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [CITY_W-1:0] frm;
    logic [CITY_W-1:0] to;
    logic [WORD_W-1:0] level;
    logic [WORD_W-1:0] frac;
    logic              typed;
    logic              want;
    city_pick_t        pick;
  } stim_row_t;

  localparam city_pick_t NO_PICK = '0;

  // directed rows run with three cities in use
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{OP_UNUSED, 6'd63, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_PICK},
    '{OP_WRITE,  6'd1,  6'd2,  32'hFFFF_FFFF, 32'h0,         1'b1, 1'b0, NO_PICK},
    '{OP_WRITE,  6'd2,  6'd1,  32'h0,         32'hFFFF_FFFF, 1'b1, 1'b0, NO_PICK},
    '{OP_WRITE,  6'd0,  6'd0,  32'h0,         32'h0,         1'b1, 1'b0, NO_PICK},
    '{OP_WRITE,  6'd63, 6'd63, 32'hFFFF_FFFF, 32'h0,         1'b1, 1'b0, NO_PICK},
    '{OP_STEP,   6'd0,  6'd0,  32'h0,         32'h0,         1'b1, 1'b1, '{6'd1, 1'b1, 1'b0}},
    '{OP_STEP,   6'd0,  6'd0,  32'h0,         32'hFFFF_FFFF, 1'b1, 1'b1, '{6'd2, 1'b0, 1'b1}},
    '{OP_STEP,   6'd0,  6'd0,  32'h0,         32'h1234_5678, 1'b1, 1'b0, NO_PICK},
    '{OP_START,  6'd0,  6'd0,  32'h0,         32'h0,         1'b1, 1'b0, NO_PICK},
    '{OP_STEP,   6'd0,  6'd0,  32'h0,         32'hFFFF_FFFF, 1'b1, 1'b1, '{6'd2, 1'b1, 1'b0}},
    '{OP_STEP,   6'd0,  6'd0,  32'h0,         32'h0,         1'b1, 1'b1, '{6'd1, 1'b1, 1'b1}},
    '{OP_STEP,   6'd0,  6'd0,  32'h0,         32'h0,         1'b1, 1'b0, NO_PICK},
    '{OP_START,  6'd0,  6'd0,  32'h0,         32'h0,         1'b1, 1'b0, NO_PICK},
    '{OP_STEP,   6'd0,  6'd0,  32'h0,         32'h8000_0000, 1'b1, 1'b1, '{6'd2, 1'b1, 1'b0}},
    '{OP_WRITE,  6'd2,  6'd1,  32'h1,         32'h0,         1'b1, 1'b0, NO_PICK},
    '{OP_STEP,   6'd0,  6'd0,  32'h0,         32'hFFFF_FFFF, 1'b1, 1'b1, '{6'd1, 1'b0, 1'b1}},
    '{OP_START,  6'd5,  6'd9,  32'h0,         32'h0,         1'b0, 1'b0, NO_PICK},
    '{OP_WRITE,  6'd0,  6'd2,  32'h0001_0000, 32'h0,         1'b0, 1'b0, NO_PICK},
    '{OP_STEP,   6'd0,  6'd0,  32'h0,         32'h9E37_79B9, 1'b0, 1'b0, NO_PICK},
    '{OP_STEP,   6'd0,  6'd0,  32'h0,         32'h7FFF_FFFF, 1'b0, 1'b0, NO_PICK},
    '{OP_UNUSED, 6'd0,  6'd0,  32'h0,         32'h0,         1'b0, 1'b0, NO_PICK}
  };

  localparam int PHASE_CITIES [NUM_PHASES] = '{3, 8, 5, 2, 16, 0, 1, 127, 12, 4, 64, 65, 6, 31,
                                               10, 3};

  logic                  clk;
  logic                  rst_n              = 1'b0;
  logic                  start              = 1'b0;
  logic                  busy;
  logic [1:0]            in_opcode          = '0;
  logic [CITY_W-1:0]     in_from_city       = '0;
  logic [CITY_W-1:0]     in_to_city         = '0;
  logic [WORD_W-1:0]     in_pheromone_value = '0;
  logic [WORD_W-1:0]     in_random_word     = '0;
  logic                  out_valid;
  logic [CITY_W-1:0]     out_next_city;
  logic                  out_chose_uniformly;
  logic                  out_tour_done;
  logic                  psel               = 1'b0;
  logic                  penable            = 1'b0;
  logic                  pwrite             = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr              = '0;
  logic [APB_DATA_W-1:0] pwdata             = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  ant_tour_next_city_selector #(
    .MAX_CITIES    (MAX_C),
    .PHEROMONE_BITS(WORD_W)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_from_city       (in_from_city),
    .in_to_city         (in_to_city),
    .in_pheromone_value (in_pheromone_value),
    .in_random_word     (in_random_word),
    .out_valid          (out_valid),
    .out_next_city      (out_next_city),
    .out_chose_uniformly(out_chose_uniformly),
    .out_tour_done      (out_tour_done),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // tour predictor state
  logic [WORD_W-1:0] pher_lvl [MAX_C][MAX_C];
  logic [MAX_C-1:0]  visited;
  logic [CITY_W-1:0] cur_city;
  int unsigned       steps_done;
  logic [CFG_W-1:0]  cities_cfg;

  city_pick_t pending_picks [$];
  int         mismatch_count = 0;
  bit         steady = 1'b0;

  function automatic void reset_tour();
    visited    = '0;
    visited[0] = 1'b1;
    cur_city   = '0;
    steps_done = 0;
  endfunction

  function automatic int unsigned eff_cities();
    return (cities_cfg > MAX_C) ? MAX_C : cities_cfg;
  endfunction

  function automatic bit predict_next_city(input logic [WORD_W-1:0] frac,
                                           output city_pick_t res);
    int unsigned       n, unv, k, seen;
    logic [63:0]       total, run, thresh;
    logic [95:0]       wide;
    logic [CITY_W-1:0] pick;
    bit                found;
    n     = eff_cities();
    unv   = 0;
    seen  = 0;
    total = '0;
    run   = '0;
    pick  = '0;
    found = 1'b0;
    res   = '0;
    if (steps_done + 1 >= n) return 1'b0;
    for (int i = 0; i < n; i++)
      if (!visited[i]) begin
        unv++;
        total += 64'(pher_lvl[cur_city][i]);
      end
    if (unv == 0) return 1'b0;
    if (total == 0) begin
      k = 32'((64'(frac) * 64'(unv)) >> 32);
      for (int i = 0; i < n; i++)
        if (!found && !visited[i]) begin
          if (seen == k) begin
            pick  = CITY_W'(i);
            found = 1'b1;
          end
          seen++;
        end
    end else begin
      wide   = 96'(frac) * 96'(total);
      thresh = wide[95:32];
      for (int i = 0; i < n; i++)
        if (!found && !visited[i]) begin
          run += 64'(pher_lvl[cur_city][i]);
          if (run > thresh) begin
            pick  = CITY_W'(i);
            found = 1'b1;
          end
        end
    end
    if (!found) return 1'b0;
    visited[pick] = 1'b1;
    cur_city      = pick;
    steps_done++;
    res.city = pick;
    res.uni  = (total == 0);
    res.done = (steps_done + 1 >= n);
    return 1'b1;
  endfunction

  function automatic bit track_command(input stim_row_t c, output city_pick_t res);
    res = '0;
    case (c.op)
      OP_WRITE: pher_lvl[c.frm][c.to] = c.level;
      OP_START: reset_tour();
      OP_STEP:  return predict_next_city(c.frac, res);
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic stim_row_t cmd(input logic [1:0] op, input logic [CITY_W-1:0] frm,
                                    input logic [CITY_W-1:0] to,
                                    input logic [WORD_W-1:0] level,
                                    input logic [WORD_W-1:0] frac);
    stim_row_t c;
    c       = '0;
    c.op    = op;
    c.frm   = frm;
    c.to    = to;
    c.level = level;
    c.frac  = frac;
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] rand_fraction();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // result beats
  always @(negedge clk) begin
    city_pick_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_picks.size() == 0) begin
        flag_mismatch("result with nothing pending", out_next_city, 0);
      end else begin
        want = pending_picks.pop_front();
        if (out_next_city !== want.city)
          flag_mismatch("next_city", out_next_city, want.city);
        if (out_chose_uniformly !== want.uni)
          flag_mismatch("chose_uniformly", out_chose_uniformly, want.uni);
        if (out_tour_done !== want.done)
          flag_mismatch("tour_done", out_tour_done, want.done);
      end
    end
  end

  // command beats
  task automatic send_cmd(input stim_row_t c);
    int         gap;
    logic       ok;
    bit         has_res;
    city_pick_t res;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 37) gap++;
      if ($urandom_range(63) == 0) gap += $urandom_range(20, 200);
    end
    repeat (gap) begin
      start          <= 1'b0;
      in_opcode      <= 2'($urandom);
      in_random_word <= $urandom;
      @(posedge clk);
    end
    start              <= 1'b1;
    in_opcode          <= c.op;
    in_from_city       <= c.frm;
    in_to_city         <= c.to;
    in_pheromone_value <= c.level;
    in_random_word     <= c.frac;
    do begin
      @(negedge clk);
      ok = (busy === 1'b0);
      @(posedge clk);
    end while (!ok);
    has_res = track_command(c, res);
    if (c.typed) begin
      if (c.want) pending_picks.push_back(c.pick);
    end else if (has_res) begin
      pending_picks.push_back(res);
    end
  endtask

  task automatic drain(input int settle);
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_picks.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (settle + 1) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_W-1:0] val,
                            output logic [APB_DATA_W-1:0] rd);
    logic rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CFG_ADDR_W'(REG_CITIES) << 2;
    pwdata  <= APB_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      rd  = prdata;
      @(posedge clk);
    end while (rdy !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_cities(input logic [CFG_W-1:0] count);
    logic [APB_DATA_W-1:0] rd;
    cfg_access(1'b1, count, rd);
    cities_cfg = count;
    cfg_access(1'b0, '0, rd);
    if (rd !== APB_DATA_W'(count)) flag_mismatch("cities_in_use readback", rd, count);
  endtask

  task automatic run_tours(input int budget);
    int                left, abort_after, taken, sel;
    bit                paused, big_set;
    logic [WORD_W-1:0] lvl;
    left    = budget;
    paused  = 1'b0;
    // above the loaded block only row zero is full, so such tours take one step
    big_set = (eff_cities() > FILL_N);
    while (left > 0) begin
      send_cmd(cmd(OP_START, 6'($urandom), 6'($urandom), $urandom, $urandom));
      left--;
      if (big_set)
        abort_after = 1;
      else
        abort_after = ($urandom_range(5) == 0) ? $urandom_range(1, 8) : MAX_C;
      taken       = 0;
      while (steps_done + 1 < eff_cities() && taken < abort_after && left > 0) begin
        if ($urandom_range(5) == 0) begin
          sel = $urandom_range(9);
          lvl = (sel < 3) ? '0 : (sel < 5) ? WORD_W'($urandom_range(1, 15)) :
                (sel < 9) ? WORD_W'($urandom) : '1;
          send_cmd(cmd(OP_WRITE, $urandom_range(1) ? cur_city : 6'($urandom), 6'($urandom),
                       lvl, $urandom));
          left--;
        end
        if ($urandom_range(24) == 0)
          send_cmd(cmd(OP_UNUSED, 6'($urandom), 6'($urandom), $urandom, $urandom));
        send_cmd(cmd(OP_STEP, 6'($urandom), 6'($urandom), $urandom, rand_fraction()));
        left--;
        taken++;
      end
      if (!big_set && $urandom_range(2) == 0)
        repeat ($urandom_range(1, 2)) begin
          send_cmd(cmd(OP_STEP, 6'($urandom), 6'($urandom), $urandom, rand_fraction()));
          left--;
        end
      if (!paused && left < budget / 2) begin
        paused = 1'b1;
        drain(0);
      end
    end
  endtask

  initial begin
    logic [WORD_W-1:0] lvl;
    cities_cfg = CITIES_RESET;
    reset_tour();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every entry a tour can read is written before any step reads it
    for (int r = 0; r < FILL_N; r++) begin
      steady = (r < FILL_N / 2);
      for (int c = 0; c < ((r == 0) ? MAX_C : FILL_N); c++) begin
        case (r % 4)
          0:       lvl = '0;
          1:       lvl = $urandom;
          2:       lvl = ($urandom_range(3) == 0) ? WORD_W'($urandom) : '0;
          default: lvl = WORD_W'($urandom_range(3));
        endcase
        send_cmd(cmd(OP_WRITE, 6'(r), 6'(c), lvl, $urandom));
      end
    end
    steady = 1'b0;

    drain(CFG_SETTLE);
    set_cities(7'd3);
    for (int i = 0; i < NUM_DIRECTED; i++) send_cmd(DIRECTED[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain(CFG_SETTLE);
      set_cities(7'(PHASE_CITIES[p]));
      steady = (p == 4);
      run_tours((eff_cities() > FILL_N) ? 20 : 60);
    end
    drain(CFG_SETTLE);

    if (pending_picks.size() != 0)
      flag_mismatch("results never delivered", pending_picks.size(), 0);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
